// ===== rtl/core/dlrn_pkg.sv =====
`default_nettype none

package dlrn_pkg;

  localparam int NAME_MAX    = 253;
  localparam int LABEL_MAX   = 63;
  localparam int STORE_DEPTH = 256;

  localparam int ADDR_W = $clog2(STORE_DEPTH);
  localparam int CNT_W  = $clog2(STORE_DEPTH + 1);

  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_USCORE = 8'h5F;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_Z   = 8'h7A;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;

  localparam logic REQ_APPEND = 1'b0;
  localparam logic REQ_FETCH  = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;

  typedef struct packed {
    logic       req_type;
    logic [7:0] char_in;
    logic       last_in;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] out_length;
    logic [7:0] out_char;
    logic       out_last;
  } out_item_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  // fold upper case to lower case
  function automatic logic [7:0] fold(input logic [7:0] c);
    if (c >= CH_UP_A && c <= CH_UP_Z) begin
      return c + (CH_LO_A - CH_UP_A);
    end
    return c;
  endfunction

  function automatic logic legal(input logic [7:0] c);
    return (c >= CH_LO_A && c <= CH_LO_Z) || (c >= CH_0 && c <= CH_9) ||
           c == CH_DASH || c == CH_USCORE;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/domain_label_reverse_normalizer_top.sv =====
`default_nettype none

// Domain name normalizer. Append items (req_type 0) write one name byte each.
// The append marked last_in validates the whole name by walking the store
// once, one byte per cycle, and returns one item with status and out_length.
// Fetch items (req_type 1) return the name with labels in reverse order: a
// byte fetch reads the store, then registers the byte for output; the fetch
// that returns a separating dot also walks backward over the preceding label
// and holds busy during that walk. A fetch with nothing pending returns
// status 2. Every result is held on out_item for exactly one cycle with
// out_valid high; the receiver cannot stall, so capture it then. start is
// taken only while busy is low. The name store holds 256 bytes with a
// registered read; bytes past it are dropped and mark the name invalid.
// No clearing pass follows reset.
module domain_label_reverse_normalizer_top
  import dlrn_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  input  wire in_item_t in_item,
  output logic          busy,
  output logic          out_valid,
  output out_item_t     out_item
);

  mem_req_t   mem_req;
  logic [7:0] mem_rdata;

  // sequencer: append, validate walk, label walk and fetch
  dlrn_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_item   (in_item),
    .rdata     (mem_rdata),
    .mem_req   (mem_req),
    .busy      (busy),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  // name bytes, stored already folded to lower case
  dlrn_store u_store (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

endmodule

`default_nettype wire

// ===== rtl/core/dlrn_store.sv =====
`default_nettype none

module dlrn_store
  import dlrn_pkg::*;
(
  input  wire logic     clk,
  input  wire mem_req_t req,
  output logic [7:0]    rdata
);

  logic [7:0] mem [STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/dlrn_ctrl.sv =====
`default_nettype none

module dlrn_ctrl
  import dlrn_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  input  wire in_item_t   in_item,
  input  wire logic [7:0] rdata,
  output mem_req_t        mem_req,
  output logic            busy,
  output logic            out_valid,
  output out_item_t       out_item
);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FIND, S_FETCH} state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  byte_count_r, byte_count_nxt;
  logic              overflow_r, overflow_nxt;
  logic              name_done_r, name_done_nxt;
  logic              result_ready_r, result_ready_nxt;
  logic [CNT_W-1:0]  label_end_r, label_end_nxt;
  logic [CNT_W-1:0]  label_start_r, label_start_nxt;
  logic [CNT_W-1:0]  emit_pos_r, emit_pos_nxt;
  logic [CNT_W-1:0]  emit_count_r, emit_count_nxt;
  logic [CNT_W-1:0]  scan_len_r, scan_len_nxt;
  logic [CNT_W-1:0]  lab_r, lab_nxt;
  logic [CNT_W-1:0]  start_pos_r, start_pos_nxt;
  logic [ADDR_W-1:0] walk_r, walk_nxt;
  logic              issue_more_r, issue_more_nxt;
  logic [ADDR_W-1:0] ridx_r, ridx_nxt;
  logic              rvld_r, rvld_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_item_r, out_item_nxt;

  always_comb begin
    logic [CNT_W-1:0] base_cnt;
    logic             base_ovf;
    logic [CNT_W-1:0] new_cnt;
    logic             new_ovf;
    logic [CNT_W-1:0] n_len;
    logic [7:0]       c;
    logic [CNT_W-1:0] lab_new;
    logic [CNT_W-1:0] start_new;
    logic             bad;
    logic             fin;

    state_nxt        = state_r;
    byte_count_nxt   = byte_count_r;
    overflow_nxt     = overflow_r;
    name_done_nxt    = name_done_r;
    result_ready_nxt = result_ready_r;
    label_end_nxt    = label_end_r;
    label_start_nxt  = label_start_r;
    emit_pos_nxt     = emit_pos_r;
    emit_count_nxt   = emit_count_r;
    scan_len_nxt     = scan_len_r;
    lab_nxt          = lab_r;
    start_pos_nxt    = start_pos_r;
    walk_nxt         = walk_r;
    issue_more_nxt   = issue_more_r;
    ridx_nxt         = ridx_r;
    rvld_nxt         = 1'b0;
    out_valid_nxt    = 1'b0;
    out_item_nxt     = out_item_r;
    mem_req          = '0;
    base_cnt         = '0;
    base_ovf         = 1'b0;
    new_cnt          = '0;
    new_ovf          = 1'b0;
    n_len            = '0;
    c                = fold(in_item.char_in);
    lab_new          = lab_r;
    start_new        = start_pos_r;
    bad              = 1'b0;
    fin              = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_item.req_type == REQ_APPEND) begin
            result_ready_nxt = 1'b0;
            base_cnt = name_done_r ? '0 : byte_count_r;
            base_ovf = name_done_r ? 1'b0 : overflow_r;
            if (base_cnt < CNT_W'(STORE_DEPTH)) begin
              mem_req.we    = 1'b1;
              mem_req.waddr = base_cnt[ADDR_W-1:0];
              mem_req.wdata = c;
              new_cnt       = base_cnt + CNT_W'(1);
              new_ovf       = base_ovf;
            end else begin
              new_cnt = base_cnt;
              new_ovf = 1'b1;
            end
            byte_count_nxt = new_cnt;
            overflow_nxt   = new_ovf;
            name_done_nxt  = in_item.last_in;
            if (in_item.last_in) begin
              n_len = (c == CH_DOT) ? new_cnt - CNT_W'(1) : new_cnt;
              if (new_ovf || n_len == '0 || 32'(n_len) > 32'(NAME_MAX)) begin
                out_valid_nxt  = 1'b1;
                out_item_nxt   = '{status: ST_INVALID, out_length: '0, out_char: '0,
                                   out_last: 1'b0};
                emit_count_nxt = '0;
              end else begin
                scan_len_nxt   = n_len;
                walk_nxt       = '0;
                issue_more_nxt = 1'b1;
                lab_nxt        = '0;
                start_pos_nxt  = '0;
                state_nxt      = S_SCAN;
              end
            end
          end else if (!result_ready_r || emit_count_r == '0) begin
            result_ready_nxt = 1'b0;
            out_valid_nxt    = 1'b1;
            out_item_nxt     = '{status: ST_EMPTY, out_length: '0, out_char: '0,
                                 out_last: 1'b0};
          end else begin
            emit_count_nxt = emit_count_r - CNT_W'(1);
            if (emit_pos_r < label_end_r) begin
              mem_req.re    = 1'b1;
              mem_req.raddr = emit_pos_r[ADDR_W-1:0];
              emit_pos_nxt  = emit_pos_r + CNT_W'(1);
              state_nxt     = S_FETCH;
            end else begin
              out_valid_nxt = 1'b1;
              out_item_nxt  = '{status: ST_OK, out_length: '0, out_char: CH_DOT,
                                out_last: (emit_count_r == CNT_W'(1))};
              if (emit_count_r == CNT_W'(1)) begin
                result_ready_nxt = 1'b0;
              end
              if (label_start_r != '0) begin
                // step to the label in front of this one
                label_end_nxt = label_start_r - CNT_W'(1);
                if (label_start_r == CNT_W'(1)) begin
                  label_start_nxt = '0;
                  emit_pos_nxt    = '0;
                end else begin
                  walk_nxt       = ADDR_W'(label_start_r - CNT_W'(2));
                  issue_more_nxt = 1'b1;
                  state_nxt      = S_FIND;
                end
              end else begin
                emit_pos_nxt = label_start_r;
              end
            end
          end
        end
      end

      S_FETCH: begin
        out_valid_nxt = 1'b1;
        out_item_nxt  = '{status: ST_OK, out_length: '0, out_char: rdata,
                          out_last: (emit_count_r == '0)};
        if (emit_count_r == '0) begin
          result_ready_nxt = 1'b0;
        end
        state_nxt = S_IDLE;
      end

      S_SCAN: begin
        // issue one read ahead, check the byte that came back
        if (issue_more_r) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = walk_r;
          ridx_nxt      = walk_r;
          rvld_nxt      = 1'b1;
          walk_nxt      = walk_r + ADDR_W'(1);
          if (CNT_W'(walk_r) == scan_len_r - CNT_W'(1)) begin
            issue_more_nxt = 1'b0;
          end
        end
        if (rvld_r) begin
          if (rdata == CH_DOT) begin
            if (lab_r == '0 || lab_r > CNT_W'(LABEL_MAX)) begin
              bad = 1'b1;
            end
            lab_new   = '0;
            start_new = CNT_W'(ridx_r) + CNT_W'(1);
          end else begin
            if (!legal(rdata)) begin
              bad = 1'b1;
            end
            lab_new = lab_r + CNT_W'(1);
          end
          lab_nxt       = lab_new;
          start_pos_nxt = start_new;
          fin = (CNT_W'(ridx_r) == scan_len_r - CNT_W'(1));
          if (fin && (lab_new == '0 || lab_new > CNT_W'(LABEL_MAX))) begin
            bad = 1'b1;
          end
          if (bad) begin
            out_valid_nxt  = 1'b1;
            out_item_nxt   = '{status: ST_INVALID, out_length: '0, out_char: '0,
                               out_last: 1'b0};
            emit_count_nxt = '0;
            rvld_nxt       = 1'b0;
            state_nxt      = S_IDLE;
          end else if (fin) begin
            out_valid_nxt    = 1'b1;
            out_item_nxt     = '{status: ST_OK, out_length: scan_len_r[7:0], out_char: '0,
                                 out_last: 1'b0};
            label_end_nxt    = scan_len_r;
            label_start_nxt  = start_new;
            emit_pos_nxt     = start_new;
            emit_count_nxt   = scan_len_r;
            result_ready_nxt = 1'b1;
            rvld_nxt         = 1'b0;
            state_nxt        = S_IDLE;
          end
        end
      end

      S_FIND: begin
        // walk backward to the dot in front of the label, or to position zero
        if (issue_more_r) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = walk_r;
          ridx_nxt      = walk_r;
          rvld_nxt      = 1'b1;
          if (walk_r == '0) begin
            issue_more_nxt = 1'b0;
          end else begin
            walk_nxt = walk_r - ADDR_W'(1);
          end
        end
        if (rvld_r && (rdata == CH_DOT || ridx_r == '0)) begin
          start_new       = (rdata == CH_DOT) ? CNT_W'(ridx_r) + CNT_W'(1) : '0;
          label_start_nxt = start_new;
          emit_pos_nxt    = start_new;
          rvld_nxt        = 1'b0;
          state_nxt       = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      byte_count_r   <= '0;
      overflow_r     <= 1'b0;
      name_done_r    <= 1'b0;
      result_ready_r <= 1'b0;
      label_end_r    <= '0;
      label_start_r  <= '0;
      emit_pos_r     <= '0;
      emit_count_r   <= '0;
      issue_more_r   <= 1'b0;
      rvld_r         <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      byte_count_r   <= byte_count_nxt;
      overflow_r     <= overflow_nxt;
      name_done_r    <= name_done_nxt;
      result_ready_r <= result_ready_nxt;
      label_end_r    <= label_end_nxt;
      label_start_r  <= label_start_nxt;
      emit_pos_r     <= emit_pos_nxt;
      emit_count_r   <= emit_count_nxt;
      issue_more_r   <= issue_more_nxt;
      rvld_r         <= rvld_nxt;
      out_valid_r    <= out_valid_nxt;
    end
    scan_len_r  <= scan_len_nxt;
    lab_r       <= lab_nxt;
    start_pos_r <= start_pos_nxt;
    walk_r      <= walk_nxt;
    ridx_r      <= ridx_nxt;
    out_item_r  <= out_item_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // the final byte read is still in flight while in S_FETCH
  a_ready_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    (result_ready_r && state_r != S_FETCH) |-> emit_count_r != '0)
    else $error("pending name with no bytes left");

  a_rvld_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    rvld_r |-> (state_r == S_SCAN || state_r == S_FIND))
    else $error("walk read outstanding outside a walk");

  // the label walk moves the label end before the fetch position follows
  a_pos_in_label: assert property (@(posedge clk) disable iff (!rst_n)
    (result_ready_r && state_r != S_FIND) |-> emit_pos_r <= label_end_r)
    else $error("fetch position beyond label end");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.status == ST_OK && out_item_r.out_last) |-> !result_ready_r)
    else $error("name still pending after last byte");

endmodule

`default_nettype wire
